### rtl/core/iirl_pkg.sv
// shared types, constants and codes for the indexed insert/remove list
package iirl_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_DUMP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NONPOS = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CO_HOLD   = 2'd0,
        CO_INSERT = 2'd1,
        CO_REMOVE = 2'd2,
        CO_ROTATE = 2'd3
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                  op;
        logic [CNT_W-1:0]          pos;
        logic [CNT_W-1:0]          last_idx;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

### rtl/core/iirl_if.sv
// request and response channel interfaces of the list
interface iirl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            opcode;
    logic [iirl_pkg::POS_W-1:0]            position;
    logic signed [iirl_pkg::DATA_W-1:0]    value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface iirl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic signed [iirl_pkg::DATA_W-1:0]    element;
    logic [iirl_pkg::LEN_W-1:0]            length;
    logic                                  last;

    modport source (output valid, output status, output element, output length, output last,
                    input ready);
    modport sink   (input valid, input status, input element, input length, input last,
                    output ready);
endinterface

### rtl/core/iirl_cell.sv
// one storage cell of the list chain
module iirl_cell (
    input  logic                                  clk,
    input  logic [iirl_pkg::IDX_W-1:0]            idx,
    input  iirl_pkg::cell_cmd_t                   cmd,
    input  logic signed [iirl_pkg::DATA_W-1:0]    left_data,
    input  logic signed [iirl_pkg::DATA_W-1:0]    right_data,
    input  logic signed [iirl_pkg::DATA_W-1:0]    head_data,
    output logic signed [iirl_pkg::DATA_W-1:0]    q
);

    logic signed [iirl_pkg::DATA_W-1:0] q_reg;
    logic signed [iirl_pkg::DATA_W-1:0] q_next;
    logic [iirl_pkg::CNT_W-1:0]         idx_ext;

    assign idx_ext = iirl_pkg::CNT_W'(idx);

    always_comb
    begin
        q_next = q_reg;
        case (cmd.op)
            iirl_pkg::CO_INSERT:
            begin
                if (idx_ext > cmd.pos)
                begin
                    q_next = left_data;
                end
                else if (idx_ext == cmd.pos)
                begin
                    q_next = cmd.value;
                end
            end
            iirl_pkg::CO_REMOVE:
            begin
                if (idx_ext >= cmd.pos)
                begin
                    q_next = right_data;
                end
            end
            iirl_pkg::CO_ROTATE:
            begin
                // live entries move down, the head wraps to the last live cell
                if (idx_ext < cmd.last_idx)
                begin
                    q_next = right_data;
                end
                else if (idx_ext == cmd.last_idx)
                begin
                    q_next = head_data;
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### rtl/core/indexed_insert_remove_list.sv
// top level: ordered list kept in a chain of cells, with control and result register
// append, insert and remove: result registered in the cycle after transfer
// dump: one result per live entry at one per cycle when the output does not stall; the
// chain rotates once per result, input is held until the last; an empty dump gives one
// result; next item is taken once the result register is free or being drained
// rst_n clears the length, the control state and the result valid; cell contents are kept
module indexed_insert_remove_list (
    input  logic       clk,
    input  logic       rst_n,
    iirl_in_if.sink    in_ch,
    iirl_out_if.source out_ch
);

    iirl_pkg::state_t  state_reg;
    iirl_pkg::state_t  state_next;

    logic [iirl_pkg::CNT_W-1:0]          count_reg;
    logic [iirl_pkg::CNT_W-1:0]          count_next;
    logic [iirl_pkg::IDX_W-1:0]          dump_idx_reg;
    logic [iirl_pkg::IDX_W-1:0]          dump_idx_next;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    iirl_pkg::status_t                   status_reg;
    iirl_pkg::status_t                   status_next;
    logic signed [iirl_pkg::DATA_W-1:0]  element_reg;
    logic signed [iirl_pkg::DATA_W-1:0]  element_next;
    logic [iirl_pkg::LEN_W-1:0]          length_reg;
    logic [iirl_pkg::LEN_W-1:0]          length_next;
    logic                                last_reg;
    logic                                last_next;

    iirl_pkg::cell_cmd_t                 cmd;
    logic signed [iirl_pkg::DATA_W-1:0]  cell_q [iirl_pkg::CAPACITY];

    iirl_pkg::opcode_t                   op;
    iirl_pkg::status_t                   edit_status;
    logic                                slot_free;
    logic                                in_fire;
    logic                                dump_step;
    logic                                dump_last;
    logic                                nonpos;
    logic                                full;
    logic [iirl_pkg::CMP_W-1:0]          pos_cmp;
    logic [iirl_pkg::CMP_W-1:0]          cnt_cmp;
    logic [iirl_pkg::CNT_W-1:0]          last_idx;

    assign op        = iirl_pkg::opcode_t'(in_ch.opcode);
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == iirl_pkg::S_IDLE) && slot_free;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign dump_step = (state_reg == iirl_pkg::S_DUMP) && slot_free;
    assign last_idx  = count_reg - iirl_pkg::CNT_W'(1);
    assign dump_last = (iirl_pkg::CNT_W'(dump_idx_reg) == last_idx);

    assign nonpos  = (in_ch.value == '0) || in_ch.value[iirl_pkg::DATA_W-1];
    assign full    = (count_reg == iirl_pkg::CNT_W'(iirl_pkg::CAPACITY));
    assign pos_cmp = iirl_pkg::CMP_W'(in_ch.position);
    assign cnt_cmp = iirl_pkg::CMP_W'(count_reg);

    always_comb
    begin
        case (op)
            iirl_pkg::OP_APPEND:
            begin
                if (nonpos)
                begin
                    edit_status = iirl_pkg::ST_NONPOS;
                end
                else if (full)
                begin
                    edit_status = iirl_pkg::ST_FULL;
                end
                else
                begin
                    edit_status = iirl_pkg::ST_OK;
                end
            end
            iirl_pkg::OP_INSERT:
            begin
                if (pos_cmp > cnt_cmp)
                begin
                    edit_status = iirl_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    edit_status = iirl_pkg::ST_FULL;
                end
                else
                begin
                    edit_status = iirl_pkg::ST_OK;
                end
            end
            iirl_pkg::OP_REMOVE:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    edit_status = iirl_pkg::ST_RANGE;
                end
                else
                begin
                    edit_status = iirl_pkg::ST_OK;
                end
            end
            default:
            begin
                edit_status = iirl_pkg::ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iirl_pkg::S_IDLE:
            begin
                if (in_fire && (op == iirl_pkg::OP_DUMP) && (count_reg != '0))
                begin
                    state_next = iirl_pkg::S_DUMP;
                end
            end
            iirl_pkg::S_DUMP:
            begin
                if (dump_step && dump_last)
                begin
                    state_next = iirl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iirl_pkg::S_IDLE;
            end
        endcase
    end

    // chain command, length and result register
    always_comb
    begin
        cmd.op         = iirl_pkg::CO_HOLD;
        cmd.pos        = iirl_pkg::CNT_W'(in_ch.position);
        cmd.last_idx   = last_idx;
        cmd.value      = in_ch.value;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        status_next    = status_reg;
        element_next   = element_reg;
        length_next    = length_reg;
        last_next      = last_reg;

        if (in_fire)
        begin
            out_valid_next = 1'b1;
            status_next    = edit_status;
            element_next   = '0;
            last_next      = 1'b1;
            dump_idx_next  = '0;
            case (op)
                iirl_pkg::OP_APPEND:
                begin
                    // append is an insert at the current length
                    cmd.pos = count_reg;
                    if (edit_status == iirl_pkg::ST_OK)
                    begin
                        cmd.op     = iirl_pkg::CO_INSERT;
                        count_next = count_reg + iirl_pkg::CNT_W'(1);
                    end
                end
                iirl_pkg::OP_INSERT:
                begin
                    if (edit_status == iirl_pkg::ST_OK)
                    begin
                        cmd.op     = iirl_pkg::CO_INSERT;
                        count_next = count_reg + iirl_pkg::CNT_W'(1);
                    end
                end
                iirl_pkg::OP_REMOVE:
                begin
                    if (edit_status == iirl_pkg::ST_OK)
                    begin
                        cmd.op     = iirl_pkg::CO_REMOVE;
                        count_next = count_reg - iirl_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    // empty dump answers at once, otherwise entries follow
                    out_valid_next = (count_reg == '0);
                end
            endcase
            length_next = iirl_pkg::LEN_W'(count_next);
        end
        else if (dump_step)
        begin
            cmd.op         = iirl_pkg::CO_ROTATE;
            out_valid_next = 1'b1;
            status_next    = iirl_pkg::ST_OK;
            element_next   = cell_q[0];
            length_next    = iirl_pkg::LEN_W'(count_reg);
            last_next      = dump_last;
            dump_idx_next  = dump_idx_reg + iirl_pkg::IDX_W'(1);
        end
    end

    for (genvar i = 0; i < iirl_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [iirl_pkg::DATA_W-1:0] left_data;
        logic signed [iirl_pkg::DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_head
            assign left_data = in_ch.value;
        end
        else
        begin : g_body
            assign left_data = cell_q[i-1];
        end

        if (i == iirl_pkg::CAPACITY - 1)
        begin : g_tail
            assign right_data = cell_q[i];
        end
        else
        begin : g_inner
            assign right_data = cell_q[i+1];
        end

        iirl_cell u_cell (
            .clk        (clk),
            .idx        (iirl_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .head_data  (cell_q[0]),
            .q          (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iirl_pkg::S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        length_reg  <= length_next;
        last_reg    <= last_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.status  = status_reg;
    assign out_ch.element = element_reg;
    assign out_ch.length  = length_reg;
    assign out_ch.last    = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= iirl_pkg::CNT_W'(iirl_pkg::CAPACITY))
        else $error("list length above capacity");

    a_edit_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op != iirl_pkg::OP_DUMP)) |=> (out_valid_reg && last_reg))
        else $error("edit transfer gave no final result");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (dump_step && dump_last) |=> ((state_reg == iirl_pkg::S_IDLE) && last_reg))
        else $error("dump did not end on its last entry");

    a_dump_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iirl_pkg::S_DUMP) |-> ((count_reg != '0) && $stable(count_reg)))
        else $error("length changed during dump");

endmodule

### tb/sv/iirl_list_checker.sv
`timescale 1ns / 1ps
// checker: mirrors the list contents and compares every response transfer
module iirl_list_checker
    import iirl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    iirl_in_if   req_mon,
    iirl_out_if  rsp_mon,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic [LEN_W-1:0]         length;
        logic                     last;
    } list_result_t;

    logic signed [DATA_W-1:0] mirror_entries [CAPACITY];
    int                       mirror_count = 0;
    list_result_t             result_q [$];
    int                       errors = 0;

    task automatic push_result(status_t st, logic signed [DATA_W-1:0] el, int len, logic lst);
        list_result_t r;
        r.status  = st;
        r.element = el;
        r.length  = LEN_W'(len);
        r.last    = lst;
        result_q.push_back(r);
    endtask

    // apply one accepted request to the mirror and queue what it should produce
    task automatic apply_request(opcode_t op, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
        status_t st;
        int      p;
        st = ST_OK;
        p  = int'(pos);
        case (op)
            OP_APPEND:
            begin
                if (val <= 0)
                    st = ST_NONPOS;
                else if (mirror_count >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    mirror_entries[mirror_count] = val;
                    mirror_count++;
                end
            end
            OP_INSERT:
            begin
                if (p > mirror_count)
                    st = ST_RANGE;
                else if (mirror_count >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (int j = mirror_count; j > p; j--)
                        mirror_entries[j] = mirror_entries[j-1];
                    mirror_entries[p] = val;
                    mirror_count++;
                end
            end
            OP_REMOVE:
            begin
                if (p >= mirror_count)
                    st = ST_RANGE;
                else
                begin
                    for (int j = p + 1; j < mirror_count; j++)
                        mirror_entries[j-1] = mirror_entries[j];
                    mirror_count--;
                end
            end
            default:
            begin
                // empty list still gives one closing result
                if (mirror_count == 0)
                    push_result(ST_OK, '0, 0, 1'b1);
                else
                    for (int k = 0; k < mirror_count; k++)
                        push_result(ST_OK, mirror_entries[k], mirror_count,
                                    k == mirror_count - 1);
                return;
            end
        endcase
        push_result(st, '0, mirror_count, 1'b1);
    endtask

    task automatic check_result();
        list_result_t exp_r;
        bit           bad;
        bad = 1'b0;
        if (result_q.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d element=%0d length=%0d last=%0b",
                     $time, rsp_mon.status, rsp_mon.element, rsp_mon.length, rsp_mon.last);
            errors++;
        end
        else
        begin
            exp_r = result_q.pop_front();
            if (rsp_mon.status !== exp_r.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_r.status, rsp_mon.status);
                bad = 1'b1;
            end
            if (rsp_mon.element !== exp_r.element)
            begin
                $display("%0t: element expected %0d actual %0d",
                         $time, exp_r.element, rsp_mon.element);
                bad = 1'b1;
            end
            if (rsp_mon.length !== exp_r.length)
            begin
                $display("%0t: length expected %0d actual %0d",
                         $time, exp_r.length, rsp_mon.length);
                bad = 1'b1;
            end
            if (rsp_mon.last !== exp_r.last)
            begin
                $display("%0t: last expected %0b actual %0b",
                         $time, exp_r.last, rsp_mon.last);
                bad = 1'b1;
            end
            if (bad)
                errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_count = 0;
            result_q.delete();
            fail_count <= errors;
            pending    <= 0;
        end
        else
        begin
            // a response at this edge always belongs to an older request
            if (rsp_mon.valid && rsp_mon.ready)
                check_result();
            if (req_mon.valid && req_mon.ready)
                apply_request(opcode_t'(req_mon.opcode), req_mon.position, req_mon.value);
            fail_count <= errors;
            pending    <= result_q.size();
        end
    end

endmodule

### tb/sv/tb_indexed_insert_remove_list.sv
`timescale 1ns / 1ps
// top: clock, reset, request stimulus, response back-pressure and verdict
module tb_indexed_insert_remove_list;
    import iirl_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 210;
    localparam int CALM_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   calm = 1'b0;
    int   steer_len = 0;  // rough list length, only to steer the stimulus

    iirl_in_if  req_ch ();
    iirl_out_if rsp_ch ();

    indexed_insert_remove_list uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (rsp_ch)
    );

    iirl_list_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("indexed_insert_remove_list test failed");
            $finish;
        end
    end

    // response back-pressure in random bursts
    initial
    begin
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            repeat (n) @(posedge clk);
            if (!calm)
            begin
                rsp_ch.ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n)
                begin
                    @(posedge clk);
                    if (calm)
                        break;
                end
            end
        end
    end

    task automatic send_request(opcode_t op, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        case (op)
            OP_APPEND: if (val > 0 && steer_len < CAPACITY) steer_len++;
            OP_INSERT: if (pos <= steer_len && steer_len < CAPACITY) steer_len++;
            OP_REMOVE: if (pos < steer_len) steer_len--;
            default: ;
        endcase
    endtask

    // pull the list length toward goal, with some out-of-range and bad values mixed in
    task automatic send_random(int goal);
        opcode_t                  op;
        int                       r;
        int                       p;
        logic signed [DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 8)
            op = OP_DUMP;
        else if (steer_len < goal)
            op = (r < 60) ? OP_APPEND : (r < 85) ? OP_INSERT : OP_REMOVE;
        else if (steer_len > goal)
            op = (r < 70) ? OP_REMOVE : (r < 85) ? OP_APPEND : OP_INSERT;
        else
            op = (r < 38) ? OP_APPEND : (r < 68) ? OP_INSERT : OP_REMOVE;

        r = $urandom_range(0, 9);
        if (r < 7)
            p = (op == OP_REMOVE && steer_len > 0) ? $urandom_range(0, steer_len - 1)
                                                   : $urandom_range(0, steer_len);
        else if (r == 7)
            p = (op == OP_INSERT) ? steer_len + 1 : steer_len;
        else if (r == 8)
            p = $urandom_range(0, 63);
        else
            p = ($urandom_range(0, 1) == 1) ? 63 : 0;

        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = $urandom() | 32'h8000_0000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'sd1;
                    default: v = -32'sd1;
                endcase
            end
            default:
            begin
                v = $urandom() & 32'h7FFF_FFFF;
                if (v == 0)
                    v = 32'sd1;
            end
        endcase
        send_request(op, POS_W'(p), v);
    endtask

    initial
    begin
        int done;
        int seg;
        int goal;
        int r;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.opcode   <= OP_APPEND;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: dump, remove and insert past the end
        send_request(OP_DUMP,   6'd0,  32'sd0);
        send_request(OP_REMOVE, 6'd0,  32'sd0);
        send_request(OP_INSERT, 6'd1,  32'sd9);
        // non-positive appends, then appends of the largest and smallest positive values
        send_request(OP_APPEND, 6'd0,  32'sd0);
        send_request(OP_APPEND, 6'd0,  -32'sd1);
        send_request(OP_APPEND, 6'd63, 32'h8000_0000);
        send_request(OP_APPEND, 6'd0,  32'h7FFF_FFFF);
        send_request(OP_APPEND, 6'd0,  32'sd1);
        // insert accepts any sign, insert at the end appends, out-of-range insert and removes, then a dump
        send_request(OP_INSERT, 6'd0,  32'h8000_0000);
        send_request(OP_INSERT, 6'd3,  32'h5A5A_A5A5);
        send_request(OP_INSERT, 6'd63, 32'sd7);
        send_request(OP_REMOVE, 6'd63, 32'sd0);
        send_request(OP_REMOVE, 6'd4,  32'sd0);
        send_request(OP_INSERT, 6'd2,  -32'sd1);
        send_request(OP_DUMP,   6'd0,  32'sd0);
        // remove head, tail and middle
        send_request(OP_REMOVE, 6'd0,  32'sd0);
        send_request(OP_REMOVE, 6'd3,  32'sd0);
        send_request(OP_REMOVE, 6'd1,  32'sd0);
        send_request(OP_DUMP,   6'd0,  32'sd0);

        // first segment fills the list so the full cases get hit early
        done = 0;
        goal = CAPACITY;
        seg  = 55;
        while (done < RANDOM_ITEMS)
        begin
            if (done == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (seg == 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    goal = CAPACITY;
                else if (r < 6)
                    goal = 0;
                else
                    goal = $urandom_range(1, CAPACITY - 1);
                seg = $urandom_range(15, 40);
            end
            send_random(goal);
            done++;
            seg--;
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("indexed_insert_remove_list test passed");
        else
            $display("indexed_insert_remove_list test failed");
        $finish;
    end

endmodule
